// ----- hw/rtl/tfr_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, codes and constants of the texel format decoder.
// No dependencies.
package tfr_pkg;

    localparam int PALETTE_DEPTH = 256;
    localparam int PAL_AW        = $clog2(PALETTE_DEPTH);
    localparam int PAL_IDX_W     = 8;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 3;
    localparam int MAX_PIX       = 8;
    localparam int CNT_W         = $clog2(MAX_PIX + 1);

    // register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] REG_FORMAT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE   = 2'd1;

    // format_code values
    localparam logic [2:0] FMT_RGBA = 3'd0;
    localparam logic [2:0] FMT_IA   = 3'd1;
    localparam logic [2:0] FMT_I    = 3'd2;
    localparam logic [2:0] FMT_CI   = 3'd3;

    // pixel_size values
    localparam logic [1:0] SIZE_4  = 2'd0;
    localparam logic [1:0] SIZE_8  = 2'd1;
    localparam logic [1:0] SIZE_16 = 2'd2;
    localparam logic [1:0] SIZE_32 = 2'd3;

    // command values
    localparam logic CMD_PAL_WRITE = 1'b0;
    localparam logic CMD_TEXELS    = 1'b1;

    // result status
    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_UNSUPPORTED = 2'd1;
    localparam logic [1:0] ST_NO_PALETTE  = 2'd2;

    localparam logic [7:0] ALPHA_FULL = 8'd255;
    localparam logic [7:0] MUL_NIB    = 8'h11;  // 4-bit to 8-bit
    localparam logic [7:0] MUL_IA3    = 8'h24;  // 3-bit to 8-bit

    typedef enum logic [3:0] {
        MODE_RGBA16 = 4'd0,
        MODE_RGBA32 = 4'd1,
        MODE_IA4    = 4'd2,
        MODE_IA8    = 4'd3,
        MODE_IA16   = 4'd4,
        MODE_I4     = 4'd5,
        MODE_I8     = 4'd6,
        MODE_CI4    = 4'd7,
        MODE_CI8    = 4'd8,
        MODE_UNSUP  = 4'd9,
        MODE_NOPAL  = 4'd10
    } t_mode;

    // one pixel slot handed from the unpacker to the decoder
    typedef struct packed {
        t_mode             mode;
        logic [31:0]       data;   // current texel sits in the top bits
        logic              last;
        logic [PAL_AW-1:0] addr;
        logic              oob;    // palette index beyond the table
    } t_slot;

    typedef struct packed {
        logic                 en;
        logic [PAL_IDX_W-1:0] idx;
        logic [15:0]          value;
    } t_pal_wr;

    // floor(v * 255 / 31)
    localparam logic [7:0] SCALE5 [32] = '{
        8'd0,   8'd8,   8'd16,  8'd24,  8'd32,  8'd41,  8'd49,  8'd57,
        8'd65,  8'd74,  8'd82,  8'd90,  8'd98,  8'd106, 8'd115, 8'd123,
        8'd131, 8'd139, 8'd148, 8'd156, 8'd164, 8'd172, 8'd180, 8'd189,
        8'd197, 8'd205, 8'd213, 8'd222, 8'd230, 8'd238, 8'd246, 8'd255
    };

    function automatic logic [7:0] scale5(input logic [4:0] v);
        return SCALE5[v];
    endfunction

endpackage

// ----- hw/rtl/tfr_req_if.sv -----
`timescale 1ns / 1ps
// Request channel: palette writes and packed texel words.
// Uses tfr_pkg for widths.
interface tfr_req_if import tfr_pkg::*; ;
    logic                 valid;
    logic                 ready;
    logic                 command;
    logic [PAL_IDX_W-1:0] palette_index;
    logic [15:0]          palette_value;
    logic [31:0]          data_word;
    logic [2:0]           valid_bytes;

    modport source(output valid, command, palette_index, palette_value, data_word,
                   valid_bytes, input ready);
    modport sink(input valid, command, palette_index, palette_value, data_word,
                 valid_bytes, output ready);
endinterface

// ----- hw/rtl/tfr_pix_if.sv -----
`timescale 1ns / 1ps
// Pixel channel: one decoded RGBA8 pixel per transfer.
// No dependencies.
interface tfr_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [1:0] status;
    logic       last_of_word;

    modport source(output valid, red, green, blue, alpha, status, last_of_word,
                   input ready);
    modport sink(input valid, red, green, blue, alpha, status, last_of_word,
                 output ready);
endinterface

// ----- hw/rtl/tfr_cfg_if.sv -----
`timescale 1ns / 1ps
// Configuration write channel: register index and write data.
// Uses tfr_pkg for widths.
interface tfr_cfg_if import tfr_pkg::*; ;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

// ----- hw/rtl/tfr_palette.sv -----
`timescale 1ns / 1ps
// Palette memory (RGBA5551 entries) with one write and one read port,
// read data registered, plus the palette-loaded flag. Uses tfr_pkg.
module tfr_palette import tfr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_pal_wr           i_wr,
    input  logic              i_rd_en,
    input  logic [PAL_AW-1:0] i_rd_addr,
    output logic [15:0]       o_rd_data,
    output logic              o_loaded
);

    logic [15:0] r_mem [PALETTE_DEPTH];
    logic [15:0] r_rd_data;
    logic        r_loaded;
    logic        wr_ok;

    assign wr_ok = i_wr.en && ({1'b0, i_wr.idx} < (PAL_IDX_W + 1)'(PALETTE_DEPTH));

    // read-first: a read and a write in the same cycle return the old entry
    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_mem[i_wr.idx[PAL_AW-1:0]] <= i_wr.value;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loaded <= 1'b0;
        end else if (wr_ok) begin
            r_loaded <= 1'b1;
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_loaded  = r_loaded;

endmodule

// ----- hw/rtl/tfr_unpack.sv -----
`timescale 1ns / 1ps
// Request intake, configuration registers and texel unpacker: splits a
// word into pixel slots, one per cycle while the decoder takes them. Uses tfr_pkg and the channel interfaces.
module tfr_unpack import tfr_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    tfr_req_if.sink         i_req,
    tfr_cfg_if.sink         i_cfg,
    input  logic            i_loaded,
    output t_pal_wr         o_pal_wr,
    output logic            o_slot_valid,
    input  logic            i_slot_ready,
    output t_slot           o_slot
);

    logic [2:0]       r_format;
    logic [1:0]       r_size;
    logic             r_a_valid;
    t_mode            r_a_mode;
    logic [31:0]      r_a_word;
    logic [CNT_W-1:0] r_a_left;

    t_mode            mode;
    logic [2:0]       nb;
    logic [CNT_W-1:0] count;
    logic             slot_fire;
    logic             req_fire;
    logic [PAL_IDX_W-1:0] idx;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format <= FMT_RGBA;
            r_size   <= SIZE_4;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_FORMAT: r_format <= i_cfg.data;
                REG_SIZE:   r_size   <= i_cfg.data[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        mode = MODE_UNSUP;
        case (r_format)
            FMT_RGBA: begin
                if (r_size == SIZE_16) mode = MODE_RGBA16;
                else if (r_size == SIZE_32) mode = MODE_RGBA32;
            end
            FMT_IA: begin
                if (r_size == SIZE_4) mode = MODE_IA4;
                else if (r_size == SIZE_8) mode = MODE_IA8;
                else if (r_size == SIZE_16) mode = MODE_IA16;
            end
            FMT_I: begin
                if (r_size == SIZE_4) mode = MODE_I4;
                else if (r_size == SIZE_8) mode = MODE_I8;
            end
            FMT_CI: begin
                if (!i_loaded) mode = MODE_NOPAL;
                else if (r_size == SIZE_4) mode = MODE_CI4;
                else if (r_size == SIZE_8) mode = MODE_CI8;
            end
            default: mode = MODE_UNSUP;
        endcase
    end

    // byte count clamps at four
    assign nb = (i_req.valid_bytes > 3'd4) ? 3'd4 : i_req.valid_bytes;

    always_comb begin
        case (mode)
            MODE_RGBA16, MODE_IA16: count = CNT_W'(nb >> 1);
            MODE_RGBA32:            count = (nb == 3'd4) ? CNT_W'(1) : '0;
            MODE_IA8, MODE_I8, MODE_CI8: count = CNT_W'(nb);
            MODE_IA4, MODE_I4, MODE_CI4: count = CNT_W'({nb, 1'b0});
            default:                count = CNT_W'(1);
        endcase
    end

    assign slot_fire   = r_a_valid && i_slot_ready;
    assign i_req.ready = !r_a_valid || (slot_fire && r_a_left == CNT_W'(1));
    assign req_fire    = i_req.valid && i_req.ready;

    assign o_pal_wr.en    = req_fire && (i_req.command == CMD_PAL_WRITE);
    assign o_pal_wr.idx   = i_req.palette_index;
    assign o_pal_wr.value = i_req.palette_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (req_fire && i_req.command == CMD_TEXELS) begin
            r_a_valid <= (count != '0);
        end else if (slot_fire && r_a_left == CNT_W'(1)) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_fire && i_req.command == CMD_TEXELS) begin
            r_a_mode <= mode;
            r_a_word <= i_req.data_word;
            r_a_left <= count;
        end else if (slot_fire) begin
            r_a_left <= r_a_left - CNT_W'(1);
            case (r_a_mode)
                MODE_IA4, MODE_I4, MODE_CI4: r_a_word <= {r_a_word[27:0], 4'h0};
                MODE_IA8, MODE_I8, MODE_CI8: r_a_word <= {r_a_word[23:0], 8'h00};
                default:                     r_a_word <= {r_a_word[15:0], 16'h0000};
            endcase
        end
    end

    assign idx = (r_a_mode == MODE_CI4) ? {4'h0, r_a_word[31:28]} : r_a_word[31:24];

    assign o_slot_valid = r_a_valid;
    assign o_slot.mode  = r_a_mode;
    assign o_slot.data  = r_a_word;
    assign o_slot.last  = (r_a_left == CNT_W'(1));
    assign o_slot.addr  = idx[PAL_AW-1:0];
    assign o_slot.oob   = ({1'b0, idx} >= (PAL_IDX_W + 1)'(PALETTE_DEPTH));

endmodule

// ----- hw/rtl/tfr_decode.sv -----
`timescale 1ns / 1ps
// Slot register alongside the palette read, color conversion to RGBA8
// and the output register. Uses tfr_pkg and tfr_pix_if.
module tfr_decode import tfr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_slot_valid,
    output logic        o_slot_ready,
    input  t_slot       i_slot,
    input  logic [15:0] i_rd_data,
    tfr_pix_if.source   o_pix
);

    logic        r_b_valid;
    t_slot       r_b;
    logic        r_c_valid;
    logic [7:0]  r_c_red, r_c_green, r_c_blue, r_c_alpha;
    logic [1:0]  r_c_status;
    logic        r_c_last;

    logic        c_ready;
    logic        b_move;
    logic [15:0] col;
    logic [3:0]  nib;
    logic [7:0]  byt;
    logic [7:0]  n_red, n_green, n_blue, n_alpha;
    logic [1:0]  n_status;

    assign c_ready      = !r_c_valid || o_pix.ready;
    assign b_move       = r_b_valid && c_ready;
    assign o_slot_ready = !r_b_valid || c_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (o_slot_ready) begin
            r_b_valid <= i_slot_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_slot_ready && i_slot_valid) begin
            r_b <= i_slot;
        end
    end

    assign nib = r_b.data[31:28];
    assign byt = r_b.data[31:24];

    // palette modes take the entry, RGBA16 the top halfword
    always_comb begin
        if (r_b.mode == MODE_CI4 || r_b.mode == MODE_CI8) begin
            col = r_b.oob ? 16'h0000 : i_rd_data;
        end else begin
            col = r_b.data[31:16];
        end
    end

    always_comb begin
        n_red    = 8'h00;
        n_green  = 8'h00;
        n_blue   = 8'h00;
        n_alpha  = 8'h00;
        n_status = ST_OK;
        case (r_b.mode)
            MODE_RGBA16, MODE_CI4, MODE_CI8: begin
                n_red   = scale5(col[15:11]);
                n_green = scale5(col[10:6]);
                n_blue  = scale5(col[5:1]);
                n_alpha = col[0] ? ALPHA_FULL : 8'h00;
            end
            MODE_RGBA32: begin
                n_red   = r_b.data[31:24];
                n_green = r_b.data[23:16];
                n_blue  = r_b.data[15:8];
                n_alpha = r_b.data[7:0];
            end
            MODE_IA4: begin
                n_red   = 8'({5'd0, nib[3:1]} * MUL_IA3);
                n_green = n_red;
                n_blue  = n_red;
                n_alpha = nib[0] ? ALPHA_FULL : 8'h00;
            end
            MODE_IA8: begin
                n_red   = 8'({4'd0, byt[7:4]} * MUL_NIB);
                n_green = n_red;
                n_blue  = n_red;
                n_alpha = 8'({4'd0, byt[3:0]} * MUL_NIB);
            end
            MODE_IA16: begin
                n_red   = byt;
                n_green = byt;
                n_blue  = byt;
                n_alpha = r_b.data[23:16];
            end
            MODE_I4: begin
                n_red   = 8'({4'd0, nib} * MUL_NIB);
                n_green = n_red;
                n_blue  = n_red;
                n_alpha = n_red;
            end
            MODE_I8: begin
                n_red   = byt;
                n_green = byt;
                n_blue  = byt;
                n_alpha = byt;
            end
            MODE_NOPAL: n_status = ST_NO_PALETTE;
            default:    n_status = ST_UNSUPPORTED;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (c_ready) begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_move) begin
            r_c_red    <= n_red;
            r_c_green  <= n_green;
            r_c_blue   <= n_blue;
            r_c_alpha  <= n_alpha;
            r_c_status <= n_status;
            r_c_last   <= r_b.last;
        end
    end

    assign o_pix.valid        = r_c_valid;
    assign o_pix.red          = r_c_red;
    assign o_pix.green        = r_c_green;
    assign o_pix.blue         = r_c_blue;
    assign o_pix.alpha        = r_c_alpha;
    assign o_pix.status       = r_c_status;
    assign o_pix.last_of_word = r_c_last;

`ifndef SYNTHESIS
    a_err_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_c_valid && r_c_status != ST_OK |-> r_c_last)
        else $error("error status on a pixel that is not last of word");
    a_err_is_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_c_valid && r_c_status != ST_OK |->
            {r_c_red, r_c_green, r_c_blue, r_c_alpha} == 32'h0)
        else $error("error status with nonzero color");
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_c_valid |-> r_c_status == ST_OK || r_c_status == ST_UNSUPPORTED
                      || r_c_status == ST_NO_PALETTE)
        else $error("undefined status code");
    a_slot_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_slot_valid && o_slot_ready |=> r_b_valid)
        else $error("issued slot lost before the decode stage");
`endif

endmodule

// ----- hw/rtl/texel_format_to_rgba8.sv -----
`timescale 1ns / 1ps
// Texel format decoder to RGBA8. A word request passes the unpack register,
// the slot register and the output register on its way to o_pix. Throughput:
// one pixel per cycle while o_pix is ready, set by the single unpack slot per
// cycle and one palette read port; a word yields 0 to 8 pixels.
// Reset (synchronous, active low) clears control, config and palette-loaded.
module texel_format_to_rgba8 import tfr_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tfr_req_if.sink   i_req,
    tfr_cfg_if.sink   i_cfg,
    tfr_pix_if.source o_pix
);

    // Pipeline: unpack (word held, shifted per slot) -> palette read
    // alongside the slot register -> conversion into the output register.
    t_pal_wr           pal_wr;
    logic              loaded;
    logic              slot_valid;
    logic              slot_ready;
    t_slot             slot;
    logic [15:0]       rd_data;

    tfr_unpack u_unpack (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (i_req),
        .i_cfg        (i_cfg),
        .i_loaded     (loaded),
        .o_pal_wr     (pal_wr),
        .o_slot_valid (slot_valid),
        .i_slot_ready (slot_ready),
        .o_slot       (slot)
    );

    // palette read issued in the same cycle a slot moves to decode
    tfr_palette u_palette (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (pal_wr),
        .i_rd_en   (slot_valid && slot_ready),
        .i_rd_addr (slot.addr),
        .o_rd_data (rd_data),
        .o_loaded  (loaded)
    );

    tfr_decode u_decode (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_slot_valid (slot_valid),
        .o_slot_ready (slot_ready),
        .i_slot       (slot),
        .i_rd_data    (rd_data),
        .o_pix        (o_pix)
    );

endmodule

// ----- tb/tfr_pixel_checker.sv -----
`timescale 1ns / 1ps
// Pixel checker for the texel format decoder: keeps its own copy of the format
// registers and the palette, predicts each pixel and compares it on o_pix.
// Depends on tfr_pkg and the request, config and pixel channel interfaces.
module tfr_pixel_checker import tfr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    tfr_req_if   i_req,
    tfr_cfg_if   i_cfg,
    tfr_pix_if   i_pix,
    output int   o_fail_count,
    output int   o_pending
);

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [1:0] status;
        logic       last;
    } t_pixel;

    logic [15:0] palette_copy [PALETTE_DEPTH];
    logic        palette_loaded;
    logic [2:0]  format_reg;
    logic [1:0]  size_reg;
    t_pixel      pixels_due [$];
    int          fail_count = 0;

    function automatic logic [7:0] expand5(input logic [4:0] v);
        return 8'((32'(v) * 255) / 31);
    endfunction

    function automatic t_pixel grey_pixel(input logic [7:0] v, input logic [7:0] a);
        t_pixel p;
        p = '{red: v, green: v, blue: v, alpha: a, status: ST_OK, last: 1'b0};
        return p;
    endfunction

    function automatic t_pixel from_5551(input logic [15:0] c);
        t_pixel p;
        p.red    = expand5(c[15:11]);
        p.green  = expand5(c[10:6]);
        p.blue   = expand5(c[5:1]);
        p.alpha  = c[0] ? 8'hFF : 8'h00;
        p.status = ST_OK;
        p.last   = 1'b0;
        return p;
    endfunction

    function automatic logic [15:0] palette_entry(input int idx);
        if (idx >= PALETTE_DEPTH)
            return 16'h0000;
        return palette_copy[idx];
    endfunction

    // pixels that one texel word turns into under the current registers
    function automatic void predict_pixels(input logic [31:0] word, input logic [2:0] nbytes);
        t_mode      mode;
        logic [7:0] src [4];
        logic [7:0] cur;
        logic [3:0] nib;
        t_pixel     px;
        int         nb;
        int         count;

        for (int i = 0; i < 4; i++)
            src[i] = word[31 - 8 * i -: 8];
        nb    = (nbytes > 3'd4) ? 4 : int'(nbytes);
        count = 0;
        mode  = MODE_UNSUP;
        case (format_reg)
            FMT_RGBA: begin
                if (size_reg == SIZE_16) mode = MODE_RGBA16;
                else if (size_reg == SIZE_32) mode = MODE_RGBA32;
            end
            FMT_IA: begin
                if (size_reg == SIZE_4) mode = MODE_IA4;
                else if (size_reg == SIZE_8) mode = MODE_IA8;
                else if (size_reg == SIZE_16) mode = MODE_IA16;
            end
            FMT_I: begin
                if (size_reg == SIZE_4) mode = MODE_I4;
                else if (size_reg == SIZE_8) mode = MODE_I8;
            end
            FMT_CI: begin
                if (!palette_loaded) mode = MODE_NOPAL;
                else if (size_reg == SIZE_4) mode = MODE_CI4;
                else if (size_reg == SIZE_8) mode = MODE_CI8;
            end
            default: mode = MODE_UNSUP;
        endcase

        case (mode)
            MODE_NOPAL, MODE_UNSUP: begin
                px = '{red: 8'd0, green: 8'd0, blue: 8'd0, alpha: 8'd0,
                       status: (mode == MODE_NOPAL) ? ST_NO_PALETTE : ST_UNSUPPORTED,
                       last: 1'b1};
                pixels_due.push_back(px);
            end
            MODE_RGBA16, MODE_IA16: begin
                for (int i = 0; i + 1 < nb; i += 2) begin
                    if (mode == MODE_RGBA16) px = from_5551({src[i], src[i + 1]});
                    else px = grey_pixel(src[i], src[i + 1]);
                    pixels_due.push_back(px);
                    count++;
                end
            end
            MODE_RGBA32: begin
                if (nb == 4) begin
                    px = '{red: src[0], green: src[1], blue: src[2], alpha: src[3],
                           status: ST_OK, last: 1'b0};
                    pixels_due.push_back(px);
                    count++;
                end
            end
            MODE_IA8, MODE_I8, MODE_CI8: begin
                for (int i = 0; i < nb; i++) begin
                    cur = src[i];
                    if (mode == MODE_IA8) px = grey_pixel(8'(cur[7:4] * 8'h11), 8'(cur[3:0] * 8'h11));
                    else if (mode == MODE_I8) px = grey_pixel(cur, cur);
                    else px = from_5551(palette_entry(int'(cur)));
                    pixels_due.push_back(px);
                    count++;
                end
            end
            default: begin
                // 4-bit texels, high nibble first
                for (int k = 0; k < 2 * nb; k++) begin
                    cur = src[k / 2];
                    nib = (k % 2 == 0) ? cur[7:4] : cur[3:0];
                    if (mode == MODE_IA4)
                        px = grey_pixel(8'(nib[3:1] * 8'h24), nib[0] ? 8'hFF : 8'h00);
                    else if (mode == MODE_I4)
                        px = grey_pixel(8'(nib * 8'h11), 8'(nib * 8'h11));
                    else
                        px = from_5551(palette_entry(int'(nib)));
                    pixels_due.push_back(px);
                    count++;
                end
            end
        endcase
        if (count > 0)
            pixels_due[pixels_due.size() - 1].last = 1'b1;
    endfunction

    function automatic int field_differs(input string name, input logic [7:0] want,
                                         input logic [7:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin
        t_pixel want;
        int     errs;

        if (!i_rst_n) begin
            format_reg     = FMT_RGBA;
            size_reg       = SIZE_4;
            palette_loaded = 1'b0;
            pixels_due.delete();
        end else begin
            if (i_pix.valid && i_pix.ready) begin
                if (pixels_due.size() == 0) begin
                    $error("pixel with nothing outstanding: r %0d g %0d b %0d a %0d status %0d",
                           i_pix.red, i_pix.green, i_pix.blue, i_pix.alpha, i_pix.status);
                    fail_count++;
                end else begin
                    want = pixels_due.pop_front();
                    errs = field_differs("red", want.red, i_pix.red)
                         + field_differs("green", want.green, i_pix.green)
                         + field_differs("blue", want.blue, i_pix.blue)
                         + field_differs("alpha", want.alpha, i_pix.alpha)
                         + field_differs("status", 8'(want.status), 8'(i_pix.status))
                         + field_differs("last_of_word", 8'(want.last), 8'(i_pix.last_of_word));
                    if (errs != 0)
                        fail_count++;
                end
            end
            if (i_cfg.valid && i_cfg.ready) begin
                if (i_cfg.index == REG_FORMAT) format_reg = i_cfg.data;
                else if (i_cfg.index == REG_SIZE) size_reg = i_cfg.data[1:0];
            end
            if (i_req.valid && i_req.ready) begin
                if (i_req.command == CMD_PAL_WRITE) begin
                    if (int'(i_req.palette_index) < PALETTE_DEPTH) begin
                        palette_copy[i_req.palette_index] = i_req.palette_value;
                        palette_loaded = 1'b1;
                    end
                end else begin
                    predict_pixels(i_req.data_word, i_req.valid_bytes);
                end
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= pixels_due.size();
    end

endmodule

// ----- tb/texel_format_to_rgba8_tb.sv -----
`timescale 1ns / 1ps
// Testbench top for texel_format_to_rgba8: drives palette and texel requests and
// format writes, stalls the pixel side, and reports the verdict.
// Depends on tfr_pkg, the channel interfaces, tfr_pixel_checker and the block.
module texel_format_to_rgba8_tb;
    import tfr_pkg::*;

    localparam int CLK_PERIOD_NS   = 20;
    localparam int LIMIT_CYCLES    = 400_000;  // far above the slowest legal run
    localparam int MAX_IDLE        = 18;       // longest sender gap per request or receiver stall per pixel
    localparam int SETTLE_CYCLES   = 16;       // settling wait after the last predicted pixel
    localparam int DRAIN_LIMIT     = 20_000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int RANDOM_PHASES   = 20;
    localparam int PHASE_ITEMS     = 16;
    localparam int N_SUPPORTED     = 9;

    // register indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;
    // format codes the block does not decode
    localparam logic [2:0] FMT_RSVD_LO = 3'd4;
    localparam logic [2:0] FMT_RSVD_HI = 3'd7;

    // every format/size pairing that decodes to pixels
    localparam logic [2:0] SUPPORTED_FMT [N_SUPPORTED] = '{
        FMT_RGBA, FMT_RGBA, FMT_IA, FMT_IA, FMT_IA, FMT_I, FMT_I, FMT_CI, FMT_CI
    };
    localparam logic [1:0] SUPPORTED_SIZE [N_SUPPORTED] = '{
        SIZE_16, SIZE_32, SIZE_4, SIZE_8, SIZE_16, SIZE_4, SIZE_8, SIZE_4, SIZE_8
    };

    logic i_clk;
    logic i_rst_n;

    tfr_req_if req_ch();
    tfr_cfg_if cfg_ch();
    tfr_pix_if pix_ch();

    int fail_count;
    int pending;

    // sender and receiver pacing
    bit sender_burst = 1'b0;     // no gaps between requests while set
    bit hold_off_pending = 1'b0; // asks the receiver for one long stall
    bit rx_eager = 1'b0;

    // palette entries the stimulus has filled; color index reads stay inside these
    bit         pal_written [PALETTE_DEPTH];
    logic [7:0] written_list [$];

    texel_format_to_rgba8 DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .i_cfg   (cfg_ch),
        .o_pix   (pix_ch)
    );

    tfr_pixel_checker pixel_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_cfg        (cfg_ch),
        .i_pix        (pix_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD_NS / 2) i_clk = ~i_clk;
    end

    initial begin
        #(LIMIT_CYCLES * CLK_PERIOD_NS);
        $display("Verification failed");
        $finish;
    end

    // One request on the input channel. The gap is drawn per request; valid stays
    // high across back-to-back requests so it is never dropped and raised in one step.
    task automatic send_request(input logic cmd, input logic [7:0] idx,
                                input logic [15:0] value, input logic [31:0] word,
                                input logic [2:0] nbytes);
        int gap;
        gap = sender_burst ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.command       <= cmd;
        req_ch.palette_index <= idx;
        req_ch.palette_value <= value;
        req_ch.data_word     <= word;
        req_ch.valid_bytes   <= nbytes;
        do @(posedge i_clk); while (!(req_ch.valid && req_ch.ready));
    endtask

    // unused fields carry noise so the block has to ignore them
    task automatic write_palette(input logic [7:0] idx, input logic [15:0] value);
        if (!pal_written[idx]) begin
            pal_written[idx] = 1'b1;
            written_list.push_back(idx);
        end
        send_request(CMD_PAL_WRITE, idx, value, $urandom, 3'($urandom_range(1, 4)));
    endtask

    task automatic write_texels(input logic [31:0] word, input logic [2:0] nbytes);
        send_request(CMD_TEXELS, 8'($urandom), 16'($urandom), word, nbytes);
    endtask

    // Drops the request valid left high by the last request, waits for every
    // predicted pixel, then lets the pipeline settle so that palette writes and
    // words with no pixel have left the block too.
    task automatic wait_idle();
        int waited;
        waited = 0;
        req_ch.valid <= 1'b0;
        do begin
            @(posedge i_clk);
            waited++;
        end while (pending != 0 && waited < DRAIN_LIMIT);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // leaves valid high; the caller lowers it after its last write
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (!(cfg_ch.valid && cfg_ch.ready));
    endtask

    // the size register holds two bits; the spare data bit is random noise
    task automatic set_mode(input logic [2:0] fmt, input logic [1:0] size);
        wait_idle();
        write_register(REG_FORMAT, fmt);
        write_register(REG_SIZE, {1'($urandom_range(0, 1)), size});
        cfg_ch.valid <= 1'b0;
    endtask

    // Pixel receiver: a random stall (bounded by MAX_IDLE) before each pixel, with
    // eager stretches, and one long hold-off when the stimulus asks for it.
    initial begin
        int stall;
        pix_ch.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_off_pending) begin
                hold_off_pending = 1'b0;
                pix_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end
            if ($urandom_range(0, 31) == 0)
                rx_eager = !rx_eager;
            stall = rx_eager ? 0 : $urandom_range(0, MAX_IDLE);
            if (stall > 0) begin
                pix_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            pix_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(pix_ch.valid && pix_ch.ready));
        end
    end

    // Stimulus: directed corners first, then random phases of one setting each.
    initial begin
        logic [2:0]  fmt;
        logic [1:0]  size;
        logic [31:0] word;
        int          pick;
        int          ph;
        int          k;
        int          bi;
        int          entry;

        i_rst_n              <= 1'b0;
        req_ch.valid         <= 1'b0;
        req_ch.command       <= CMD_TEXELS;
        req_ch.palette_index <= '0;
        req_ch.palette_value <= '0;
        req_ch.data_word     <= '0;
        req_ch.valid_bytes   <= 3'd4;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.index         <= REG_FORMAT;
        cfg_ch.data          <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --- directed part ---
        // reset leaves RGBA at 4 bits, which is not a decodable pairing
        write_texels(32'hFFFF_FFFF, 3'd4);
        // color index before any palette write: no-palette status at any size
        set_mode(FMT_CI, SIZE_8);
        write_texels(32'h1234_5678, 3'd4);
        set_mode(FMT_CI, SIZE_32);
        write_texels(32'h0000_0000, 3'd1);
        // RGBA 5551: extremes, a lone byte (no pixel) and a dropped trailing byte
        set_mode(FMT_RGBA, SIZE_16);
        write_texels(32'h0000_0000, 3'd4);
        write_texels(32'hFFFF_FFFF, 3'd4);
        write_texels(32'hFFFF_FFFF, 3'd1);
        write_texels(32'h8421_F0E1, 3'd3);
        // RGBA 8888 passthrough; three bytes do not make a pixel
        set_mode(FMT_RGBA, SIZE_32);
        write_texels(32'hFFFF_FFFF, 3'd4);
        write_texels(32'h0011_2233, 3'd4);
        write_texels(32'hDEAD_BEEF, 3'd3);
        // intensity/alpha at every decodable size
        set_mode(FMT_IA, SIZE_4);
        write_texels(32'hFFFF_FFFF, 3'd4);
        write_texels(32'h0123_4567, 3'd1);
        set_mode(FMT_IA, SIZE_8);
        write_texels(32'hF00F_A55A, 3'd4);
        set_mode(FMT_IA, SIZE_16);
        write_texels(32'hFF00_00FF, 3'd4);
        write_texels(32'h8000_0000, 3'd1);
        // intensity only
        set_mode(FMT_I, SIZE_4);
        write_texels(32'h0123_4567, 3'd4);
        set_mode(FMT_I, SIZE_8);
        write_texels(32'h00FF_7F80, 3'd4);
        set_mode(FMT_I, SIZE_16);
        write_texels(32'h89AB_CDEF, 3'd2);
        // palette ends and full/empty colors, then lookups of just those entries
        write_palette(8'd0, 16'hFFFF);
        write_palette(8'd255, 16'h0000);
        write_palette(8'd15, 16'hA5A5);
        set_mode(FMT_CI, SIZE_4);
        write_texels(32'h0F0F_F0F0, 3'd4);
        set_mode(FMT_CI, SIZE_8);
        write_texels(32'h00FF_FF00, 3'd4);
        // wide color index with a palette loaded is unsupported
        set_mode(FMT_CI, SIZE_16);
        write_texels(32'hFFFF_FFFF, 3'd4);
        // reserved formats
        set_mode(FMT_RSVD_HI, SIZE_32);
        write_texels(32'h1357_9BDF, 3'd2);
        set_mode(FMT_RSVD_LO, SIZE_4);
        write_texels(32'h2468_ACE0, 3'd4);

        // the spare register slots must be harmless
        wait_idle();
        write_register(REG_SPARE_LO, 3'($urandom));
        write_register(REG_SPARE_HI, 3'($urandom));
        cfg_ch.valid <= 1'b0;

        // fill the low entries so any 4-bit index is a legal lookup
        for (entry = 1; entry < 15; entry++)
            write_palette(8'(entry), 16'($urandom));

        // --- back-pressure: 8-pixel words into a stalled receiver ---
        set_mode(FMT_I, SIZE_4);
        sender_burst = 1'b1;
        hold_off_pending = 1'b1;
        repeat (12) write_texels($urandom, 3'd4);
        sender_burst = 1'b0;

        // --- random phases: mostly decodable settings, some of any kind ---
        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            if ($urandom_range(0, 4) == 0) begin
                fmt  = 3'($urandom_range(0, 7));
                size = 2'($urandom_range(0, 3));
            end else begin
                pick = $urandom_range(0, N_SUPPORTED - 1);
                fmt  = SUPPORTED_FMT[pick];
                size = SUPPORTED_SIZE[pick];
            end
            set_mode(fmt, size);
            sender_burst = ($urandom_range(0, 3) == 0);
            for (k = 0; k < PHASE_ITEMS; k++) begin
                // palette updates interleaved with lookups, right up against them
                if (fmt == FMT_CI && $urandom_range(0, 7) == 0) begin
                    write_palette(8'($urandom), 16'($urandom));
                end else begin
                    word = $urandom;
                    // 8-bit indexes only point at entries already written
                    if (fmt == FMT_CI && size == SIZE_8) begin
                        for (bi = 0; bi < 4; bi++)
                            word[8 * bi +: 8] =
                                written_list[$urandom_range(0, written_list.size() - 1)];
                    end
                    write_texels(word, 3'($urandom_range(1, 4)));
                end
            end
        end
        sender_burst = 1'b0;

        wait_idle();
        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- texel_format_to_rgba8.f -----
hw/rtl/tfr_pkg.sv
hw/rtl/tfr_req_if.sv
hw/rtl/tfr_pix_if.sv
hw/rtl/tfr_cfg_if.sv
hw/rtl/tfr_palette.sv
hw/rtl/tfr_unpack.sv
hw/rtl/tfr_decode.sv
hw/rtl/texel_format_to_rgba8.sv
tb/tfr_pixel_checker.sv
tb/texel_format_to_rgba8_tb.sv
